// ----- design/hse_pkg.sv -----
// Shared types and constants for the heap sort engine.
package hse_pkg;
	localparam int unsigned ADDR_SORT_DESC = 0;

	typedef struct packed {
		logic last;
		logic ovf;
	} batch_info_t;
endpackage

// ----- design/hse_front.sv -----
// Front end: accepts keys, counts the batch, hands a load or close word to the queue.
module hse_front #(
	parameter int MAX_ITEMS = 64,
	parameter int KEY_BITS  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [KEY_BITS-1:0]  s_key,
	input  logic                 s_last,
	output logic                 q_valid,
	input  logic                 q_ready,
	output logic [KEY_BITS-1:0]  q_key,
	output logic                 q_store,
	output hse_pkg::batch_info_t q_info
);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	logic [CW-1:0] count_q;
	logic          drop_q;
	logic          full;
	logic          acc;
	logic          pop;

	logic [KEY_BITS-1:0]  fkey_q [2];
	logic                 fstore_q [2];
	hse_pkg::batch_info_t finfo_q [2];
	hse_pkg::batch_info_t in_info;
	logic                 wp_q, rp_q;
	logic [1:0]           fcnt_q;

	assign full         = (count_q == CW'(MAX_ITEMS));
	assign s_tready     = (fcnt_q != 2'd2);
	assign acc          = s_tvalid & s_tready;
	assign pop          = q_valid & q_ready;
	assign in_info.last = s_last;
	assign in_info.ovf  = drop_q | full;
	assign q_valid      = (fcnt_q != 2'd0);
	assign q_key        = fkey_q[rp_q];
	assign q_store      = fstore_q[rp_q];
	assign q_info       = finfo_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fkey_q[0]   <= '0;
			fkey_q[1]   <= '0;
			fstore_q[0] <= 1'b0;
			fstore_q[1] <= 1'b0;
			finfo_q[0]  <= '0;
			finfo_q[1]  <= '0;
			wp_q        <= 1'b0;
			rp_q        <= 1'b0;
			fcnt_q      <= '0;
		end else begin
			if (acc) begin
				fkey_q[wp_q]   <= s_key;
				fstore_q[wp_q] <= !full;
				finfo_q[wp_q]  <= in_info;
				wp_q           <= ~wp_q;
			end
			if (pop)
				rp_q <= ~rp_q;
			fcnt_q <= fcnt_q + 2'(acc) - 2'(pop);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
		end else if (acc) begin
			if (s_last) begin
				count_q <= '0;
				drop_q  <= 1'b0;
			end else if (full) begin
				drop_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end
endmodule

// ----- design/hse_back.sv -----
// Back end: key memory, heap build and extraction sequencer, result emission.
module hse_back #(
	parameter int MAX_ITEMS = 64,
	parameter int KEY_BITS  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 desc,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  logic [KEY_BITS-1:0]  q_key,
	input  logic                 q_store,
	input  hse_pkg::batch_info_t q_info,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_key,
	output logic                 m_last,
	output logic                 m_ovf
);
	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int IW = AW + 2;

	typedef enum logic [11:0] {
		ST_LOAD = 12'b000000000001,
		ST_RDV  = 12'b000000000010,
		ST_GETV = 12'b000000000100,
		ST_CHK  = 12'b000000001000,
		ST_RDR  = 12'b000000010000,
		ST_CMP  = 12'b000000100000,
		ST_SWA  = 12'b000001000000,
		ST_SWB  = 12'b000010000000,
		ST_SWC  = 12'b000100000000,
		ST_SWD  = 12'b001000000000,
		ST_EMR  = 12'b010000000000,
		ST_EM   = 12'b100000000000
	} state_t;

	state_t              st_q;
	logic [KEY_BITS-1:0] mem [MAX_ITEMS];
	logic [KEY_BITS-1:0] rd_q, v_q, l_q, a_q;
	logic [CW-1:0]       n_q, cnt_q;
	logic [IW-1:0]       top_q, hole_q, end_q, ptr_q;
	logic                ovf_q, build_q;

	logic                we;
	logic [AW-1:0]       wa, ra;
	logic [KEY_BITS-1:0] wd;
	logic                re;

	logic [IW-1:0]       child, child_r, last_ptr;
	logic [KEY_BITS-1:0] best;
	logic [IW-1:0]       bidx;
	logic                sw;
	logic                sift_done;
	logic [CW-1:0]       n_new;
	logic                out_free, emit;

	function automatic logic bef(input logic d, input logic [KEY_BITS-1:0] a,
			input logic [KEY_BITS-1:0] b);
		bef = d ? (a > b) : (a < b);
	endfunction

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rd_q <= mem[ra];
	end

	assign child    = {hole_q[IW-2:0], 1'b1};
	assign child_r  = child + IW'(1);
	assign last_ptr = IW'(n_q) - IW'(1);
	assign n_new    = q_store ? cnt_q + 1'b1 : cnt_q;
	assign q_ready  = (st_q == ST_LOAD);
	assign out_free = !m_tvalid || m_tready;
	assign emit     = (st_q == ST_EM) && out_free;

	always_comb begin
		best = l_q; bidx = child;
		if (child < end_q && bef(desc, l_q, rd_q)) begin
			best = rd_q; bidx = child_r;
		end
	end

	assign sw        = bef(desc, v_q, best);
	assign sift_done = ((st_q == ST_CHK) && (child > end_q)) || ((st_q == ST_CMP) && !sw);

	always_comb begin
		we = 1'b0; wa = '0; wd = q_key; re = 1'b0; ra = '0;
		case (st_q)
			ST_LOAD: begin
				we = q_valid & q_store; wa = AW'(cnt_q);
			end
			ST_RDV: begin re = 1'b1; ra = AW'(hole_q); end
			ST_CHK: begin
				if (child > end_q) begin
					we = 1'b1; wa = AW'(hole_q); wd = v_q;
				end else begin
					re = 1'b1; ra = AW'(child);
				end
			end
			ST_RDR: begin re = 1'b1; ra = AW'(child_r); end
			ST_CMP: begin
				we = 1'b1; wa = AW'(hole_q); wd = sw ? best : v_q;
			end
			ST_SWA: begin re = 1'b1; ra = '0; end
			ST_SWB: begin re = 1'b1; ra = AW'(end_q); end
			ST_SWC: begin we = 1'b1; wa = '0; wd = rd_q; end
			ST_SWD: begin we = 1'b1; wa = AW'(end_q); wd = a_q; end
			ST_EMR: begin re = 1'b1; ra = AW'(ptr_q); end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD; cnt_q <= '0; n_q <= '0; ovf_q <= 1'b0;
			build_q <= 1'b0; top_q <= '0; hole_q <= '0; end_q <= '0;
			ptr_q <= '0; v_q <= '0; l_q <= '0; a_q <= '0;
		end else begin
			case (st_q)
				ST_LOAD: if (q_valid) begin
					if (q_info.last) begin
						n_q   <= n_new;
						ovf_q <= q_info.ovf;
						cnt_q <= '0;
						if (n_new >= CW'(2)) begin
							top_q   <= IW'(n_new >> 1) - IW'(1);
							hole_q  <= IW'(n_new >> 1) - IW'(1);
							end_q   <= IW'(n_new) - IW'(1);
							build_q <= 1'b1;
							st_q    <= ST_RDV;
						end else begin
							ptr_q <= '0; st_q <= ST_EMR;
						end
					end else if (q_store) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_RDV:  st_q <= ST_GETV;
				ST_GETV: begin v_q <= rd_q; st_q <= ST_CHK; end
				ST_RDR:  begin l_q <= rd_q; st_q <= ST_CMP; end
				ST_CHK, ST_CMP: begin
					if (sift_done) begin
						if (build_q) begin
							if (top_q == '0) begin
								build_q <= 1'b0; st_q <= ST_SWA;
							end else begin
								top_q  <= top_q - 1'b1;
								hole_q <= top_q - 1'b1;
								st_q   <= ST_RDV;
							end
						end else begin
							st_q <= ST_SWA;
						end
					end else if (st_q == ST_CHK) begin
						st_q <= ST_RDR;
					end else begin
						hole_q <= bidx; st_q <= ST_CHK;
					end
				end
				ST_SWA: st_q <= ST_SWB;
				ST_SWB: begin a_q <= rd_q; st_q <= ST_SWC; end
				ST_SWC: st_q <= ST_SWD;
				ST_SWD: begin
					if (end_q > IW'(1)) begin
						end_q <= end_q - 1'b1; top_q <= '0; hole_q <= '0; st_q <= ST_RDV;
					end else begin
						ptr_q <= '0; st_q <= ST_EMR;
					end
				end
				ST_EMR: st_q <= ST_EM;
				ST_EM: if (out_free) begin
					if (ptr_q == last_ptr) st_q <= ST_LOAD;
					else begin ptr_q <= ptr_q + 1'b1; st_q <= ST_EMR; end
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0; m_key <= '0; m_last <= 1'b0; m_ovf <= 1'b0;
		end else if (emit) begin
			m_tvalid <= 1'b1;
			m_key    <= 32'(rd_q);
			m_last   <= (ptr_q == last_ptr);
			m_ovf    <= ovf_q;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end
endmodule

// ----- design/heap_sort_engine.sv -----
// Top level of the heap sort engine: APB register, front end and sort back end.
// Keys are loaded one per word and, while the back end loads, one per cycle through
// a two-word queue; the word flagged tlast closes the batch and the back end heapsorts
// it in a key memory with one registered read a cycle. Each sift-down reads the hole
// key (RDV, GETV), then runs CHK, RDR and CMP per level; each root swap runs SWA,
// SWB, SWC and SWD. The sorted keys then leave one at a time, each read (EMR) then
// sent (EM). Input stalls once the queue is full while a batch is sorted and emitted.
module heap_sort_engine #(
	parameter int MAX_ITEMS = 64,
	parameter int KEY_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // key_value
	input  logic        s_axis_tlast,  // is_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // sorted_key
	output logic        m_axis_tlast,  // last_out
	output logic        m_axis_tuser   // overflow_seen
);
	logic desc_q;
	logic q_valid, q_ready, q_store;
	logic [KEY_BITS-1:0] q_key;
	hse_pkg::batch_info_t q_info;
	logic [KEY_BITS-1:0] in_key;

	assign in_key = KEY_BITS'({{(KEY_BITS > 32 ? KEY_BITS - 32 : 1){1'b0}}, s_axis_tdata});
	assign pready = 1'b1;
	assign prdata = {31'd0, desc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) desc_q <= 1'b0;
		else if (psel && penable && pwrite && paddr == 1'(hse_pkg::ADDR_SORT_DESC))
			desc_q <= pwdata[0];
	end

	hse_front #(.MAX_ITEMS(MAX_ITEMS), .KEY_BITS(KEY_BITS)) u_front (
		.clk, .arst_n, .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
		.s_key(in_key), .s_last(s_axis_tlast), .q_valid, .q_ready, .q_key,
		.q_store, .q_info
	);

	hse_back #(.MAX_ITEMS(MAX_ITEMS), .KEY_BITS(KEY_BITS)) u_back (
		.clk, .arst_n, .desc(desc_q), .q_valid, .q_ready, .q_key, .q_store, .q_info,
		.m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_key(m_axis_tdata),
		.m_last(m_axis_tlast), .m_ovf(m_axis_tuser)
	);
endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the heap sort engine: batched keys in, sorted words out.
`timescale 1ns / 1ps

class sort_scoreboard;
	bit [31:0] batch_keys[$];
	bit        batch_ovf;
	bit        descending;
	bit [33:0] pending[$];
	int        errors;

	function void note_key(bit [31:0] key, bit last);
		bit [31:0] sorted[$];
		int n;
		if (batch_keys.size() < 64)
			batch_keys.push_back(key);
		else
			batch_ovf = 1;
		if (!last)
			return;
		sorted = batch_keys;
		if (descending)
			sorted.rsort();
		else
			sorted.sort();
		n = sorted.size();
		foreach (sorted[k])
			pending.push_back({batch_ovf, (k == n - 1) ? 1'b1 : 1'b0, sorted[k]});
		batch_keys.delete();
		batch_ovf = 0;
	endfunction

	function void check_word(bit [31:0] key, bit last, bit ovf);
		bit [33:0] exp;
		if (pending.size() == 0) begin
			$display("%0t: unexpected word key=%h last=%b ovf=%b", $time, key, last, ovf);
			errors++;
			return;
		end
		exp = pending.pop_front();
		if (exp[31:0] !== key) begin
			$display("%0t: key expected %h actual %h", $time, exp[31:0], key);
			errors++;
		end
		if (exp[32] !== last) begin
			$display("%0t: last expected %b actual %b", $time, exp[32], last);
			errors++;
		end
		if (exp[33] !== ovf) begin
			$display("%0t: overflow expected %b actual %b", $time, exp[33], ovf);
			errors++;
		end
	endfunction
endclass

module tb;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [0:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = 0;  // key_value
	logic        s_axis_tlast = 0;  // is_last
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;      // sorted_key
	logic        m_axis_tlast;      // last_out
	logic        m_axis_tuser;      // overflow_seen

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  hold_off = 0;
	sort_scoreboard board = new();

	heap_sort_engine DUT (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_axis_tready <= 0;
		end else
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic write_order(bit desc);
		@(posedge clk);
		psel <= 1; pwrite <= 1; paddr <= 1'(hse_pkg::ADDR_SORT_DESC); pwdata <= {31'b0, desc};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		board.descending = desc;
	endtask

	task automatic send_key(bit [31:0] key, bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1; s_axis_tdata <= key; s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		board.note_key(key, last);
	endtask

	task automatic drain;
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic bit [31:0] rand_key();
		case ($urandom_range(3))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(7);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_batch(int n);
		for (int i = 0; i < n; i++)
			send_key(rand_key(), i == n - 1);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);
		// directed
		send_key(32'h1234_5678, 1);
		send_batch(2);
		send_key(32'hFFFF_FFFF, 0); send_key(0, 0); send_key(5, 0); send_key(5, 1);
		drain();
		write_order(1);
		send_key(32'h0, 0); send_key(32'hFFFF_FFFF, 0); send_key(32'h8000_0001, 0);
		send_key(32'h7FFF_FFFE, 1);
		drain();
		// overflow: 66 keys, last one dropped too
		write_order(0);
		for (int i = 0; i < 66; i++) send_key($urandom, i == 65);
		drain();
		// random phases
		for (int ph = 0; ph < 4; ph++) begin
			write_order(ph[0]);
			send_idle_pct = (ph == 1 || ph == 3) ? 87 : 0;
			recv_stall_pct = (ph == 2) ? 87 : 0;
			if (ph == 3) begin
				send_idle_pct = 16; recv_stall_pct = 16;
			end
			if (ph == 0) hold_off = 600;
			for (int b = 0; b < 4; b++)
				send_batch($urandom_range(1, 8));
			send_batch($urandom_range(8, 20));
			drain();
		end
		if (board.errors == 0 && board.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ----- files.f -----
design/hse_pkg.sv
design/hse_front.sv
design/hse_back.sv
design/heap_sort_engine.sv
bench/tb.sv
